// ===== hdl/tksi_pkg.sv =====
// Shared constants, command codes and result type for the top-K insertion list.
package tksi_pkg;

  localparam int LIST_DEPTH = 32;
  localparam int IDX_W      = $clog2(LIST_DEPTH);
  localparam int CNT_W      = $clog2(LIST_DEPTH + 1);

  localparam int KEY_W      = 32;
  localparam int TAG_W      = 16;
  localparam int RIDX_W     = 5;
  localparam int PLACE_W    = 5;
  localparam int FILL_W     = 6;
  localparam int ENT_W      = KEY_W + TAG_W;

  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 64;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_READ   = 1'b1;

  typedef struct packed {
    logic               accepted;
    logic [PLACE_W-1:0] place;
    logic               entry_valid;
    logic [KEY_W-1:0]   entry_key;
    logic [TAG_W-1:0]   entry_tag;
    logic [FILL_W-1:0]  fill_count;
  } res_t;

endpackage

// ===== hdl/tksi_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module tksi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/tksi_cmp.sv =====
// Shared key comparator: does the candidate beat or tie the held key.
module tksi_cmp
  import tksi_pkg::*;
(
  input  logic             keep_largest,
  input  logic [KEY_W-1:0] cand_key,
  input  logic [KEY_W-1:0] held_key,
  output logic             beats
);

  always_comb begin
    if (keep_largest) begin
      beats = (cand_key >= held_key);
    end else begin
      beats = (cand_key <= held_key);
    end
  end

endmodule

// ===== hdl/tksi_seq.sv =====
// Sequencer: scans, shifts and writes the list RAM one entry at a time, and serves reads.
module tksi_seq
  import tksi_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_cmd,
  input  logic [KEY_W-1:0]  in_key,
  input  logic [TAG_W-1:0]  in_tag,
  input  logic [RIDX_W-1:0] in_ridx,
  output logic              ram_we,
  output logic [IDX_W-1:0]  ram_waddr,
  output logic [ENT_W-1:0]  ram_wdata,
  output logic              ram_re,
  output logic [IDX_W-1:0]  ram_raddr,
  input  logic [ENT_W-1:0]  ram_rdata,
  output logic [KEY_W-1:0]  cand_key,
  input  logic              beats,
  output logic              res_valid,
  input  logic              res_ready,
  output res_t              res
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_READ_RD  = 4'd1;
  localparam logic [3:0] S_SCAN_RD  = 4'd2;
  localparam logic [3:0] S_SCAN_CMP = 4'd3;
  localparam logic [3:0] S_SHIFT_RD = 4'd4;
  localparam logic [3:0] S_SHIFT_WR = 4'd5;
  localparam logic [3:0] S_PLACE    = 4'd6;
  localparam logic [3:0] S_DONE     = 4'd7;

  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(LIST_DEPTH);
  localparam logic [CNT_W-1:0] LAST_C  = CNT_W'(LIST_DEPTH - 1);

  logic [3:0]        state_r, state_nxt;
  logic [CNT_W-1:0]  idx_r, idx_nxt;
  logic [CNT_W-1:0]  pos_r, pos_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              cmd_r, cmd_nxt;
  logic [KEY_W-1:0]  key_r, key_nxt;
  logic [TAG_W-1:0]  tag_r, tag_nxt;
  logic [RIDX_W-1:0] ridx_r, ridx_nxt;
  logic              acc_r, acc_nxt;
  logic              rvalid_r, rvalid_nxt;
  logic [CNT_W-1:0]  last_idx;

  // Highest slot touched by a shift: the free slot, or the tail when full.
  assign last_idx = (count_r < DEPTH_C) ? count_r : LAST_C;

  always_comb begin
    logic [CNT_W-1:0] p;
    p          = '0;
    state_nxt  = state_r;
    idx_nxt    = idx_r;
    pos_nxt    = pos_r;
    count_nxt  = count_r;
    cmd_nxt    = cmd_r;
    key_nxt    = key_r;
    tag_nxt    = tag_r;
    ridx_nxt   = ridx_r;
    acc_nxt    = acc_r;
    rvalid_nxt = rvalid_r;
    ram_we     = 1'b0;
    ram_waddr  = '0;
    ram_wdata  = {tag_r, key_r};
    ram_re     = 1'b0;
    ram_raddr  = '0;
    res_valid  = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt    = in_cmd;
          key_nxt    = in_key;
          tag_nxt    = in_tag;
          ridx_nxt   = in_ridx;
          acc_nxt    = 1'b0;
          rvalid_nxt = 1'b0;
          pos_nxt    = '0;
          idx_nxt    = '0;
          if (in_cmd == CMD_READ) begin
            if (32'(in_ridx) < 32'(count_r)) begin
              rvalid_nxt = 1'b1;
              state_nxt  = S_READ_RD;
            end else begin
              state_nxt = S_DONE;
            end
          end else if (count_r == '0) begin
            state_nxt = S_PLACE;
          end else begin
            state_nxt = S_SCAN_RD;
          end
        end
      end
      S_READ_RD: begin
        ram_re    = 1'b1;
        ram_raddr = IDX_W'(ridx_r);
        state_nxt = S_DONE;
      end
      S_SCAN_RD: begin
        ram_re    = 1'b1;
        ram_raddr = idx_r[IDX_W-1:0];
        state_nxt = S_SCAN_CMP;
      end
      S_SCAN_CMP: begin
        if (beats || (idx_r == count_r - 1'b1)) begin
          p = beats ? idx_r : count_r;
          if (!beats && (count_r == DEPTH_C)) begin
            // full and beats nothing: drop
            state_nxt = S_DONE;
          end else begin
            pos_nxt   = p;
            idx_nxt   = last_idx;
            state_nxt = (last_idx > p) ? S_SHIFT_RD : S_PLACE;
          end
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_SCAN_RD;
        end
      end
      S_SHIFT_RD: begin
        ram_re    = 1'b1;
        ram_raddr = IDX_W'(idx_r - 1'b1);
        state_nxt = S_SHIFT_WR;
      end
      S_SHIFT_WR: begin
        ram_we    = 1'b1;
        ram_waddr = idx_r[IDX_W-1:0];
        ram_wdata = ram_rdata;
        idx_nxt   = idx_r - 1'b1;
        state_nxt = ((idx_r - 1'b1) > pos_r) ? S_SHIFT_RD : S_PLACE;
      end
      S_PLACE: begin
        ram_we    = 1'b1;
        ram_waddr = pos_r[IDX_W-1:0];
        if (count_r < DEPTH_C) begin
          count_nxt = count_r + 1'b1;
        end
        acc_nxt   = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r    <= idx_nxt;
    pos_r    <= pos_nxt;
    cmd_r    <= cmd_nxt;
    key_r    <= key_nxt;
    tag_r    <= tag_nxt;
    ridx_r   <= ridx_nxt;
    acc_r    <= acc_nxt;
    rvalid_r <= rvalid_nxt;
  end

  assign in_ready = (state_r == S_IDLE);
  assign cand_key = key_r;

  // Read data stays put after the read issue until the next transfer in.
  always_comb begin
    res.accepted    = acc_r;
    res.place       = (cmd_r == CMD_READ) ? ridx_r : PLACE_W'(pos_r);
    res.entry_valid = rvalid_r;
    res.entry_key   = rvalid_r ? ram_rdata[KEY_W-1:0] : '0;
    res.entry_tag   = rvalid_r ? ram_rdata[ENT_W-1:KEY_W] : '0;
    res.fill_count  = FILL_W'(count_r);
  end

endmodule

// ===== hdl/top_k_sorted_insert_two_way.sv =====
// Top level of the top-K sorted insertion list with stream ports.
//
// Holds up to 32 key/tag entries in one RAM, kept sorted ascending or
// descending per cfg_wr_data (1 = keep largest). Each transfer in yields one
// result. An insert compares the list from the head, one entry at a time,
// through a single comparator and the RAM's registered read port, then moves
// each displaced entry down one slot, again one entry at a time, and writes
// the new item. A read fetches the indexed entry unless the index lies
// beyond the fill. The result then waits in an output register; in_tready
// stays low from each transfer in until its result moves into that register.
module top_k_sorted_insert_two_way
  import tksi_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic                  cfg_wr_data,   // keep_largest
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // item_key[31:0], item_tag[47:32], read_index[52:48], zero [55:53]
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // command
  input  logic                  in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // accepted[0], place[5:1], entry_valid[6], entry_key[38:7],
  // entry_tag[54:39], fill_count[60:55], zero [63:61]
  output logic [OUT_DATA_W-1:0] out_tdata
);

  logic                  keep_largest_r;
  logic                  ram_we;
  logic [IDX_W-1:0]      ram_waddr;
  logic [ENT_W-1:0]      ram_wdata;
  logic                  ram_re;
  logic [IDX_W-1:0]      ram_raddr;
  logic [ENT_W-1:0]      ram_rdata;
  logic [KEY_W-1:0]      cand_key;
  logic                  beats;
  logic                  res_valid;
  logic                  res_ready;
  res_t                  res;
  logic                  out_tvalid_r;
  logic [OUT_DATA_W-1:0] out_tdata_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      keep_largest_r <= 1'b1;
    end else if (cfg_wr_en) begin
      keep_largest_r <= cfg_wr_data;
    end
  end

  tksi_ram #(
    .WIDTH (ENT_W),
    .DEPTH (LIST_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  tksi_cmp u_cmp (
    .keep_largest (keep_largest_r),
    .cand_key     (cand_key),
    .held_key     (ram_rdata[KEY_W-1:0]),
    .beats        (beats)
  );

  tksi_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_cmd    (in_tuser),
    .in_key    (in_tdata[31:0]),
    .in_tag    (in_tdata[47:32]),
    .in_ridx   (in_tdata[52:48]),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .cand_key  (cand_key),
    .beats     (beats),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // Output register frees the sequencer once the result is captured.
  assign res_ready = !out_tvalid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (res_ready) begin
      out_tvalid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_tdata_r <= {3'b000, res.fill_count, res.entry_tag, res.entry_key,
                      res.entry_valid, res.place, res.accepted};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

// ===== hdl/tksi_chk.sv =====
// Port-level checker for the top-K insertion list, bound to the top level.
module tksi_chk
  import tksi_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata
);

  // reset leaves the block empty-handed and ready
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> (!out_tvalid && in_tready))
    else $error("block not idle after reset");

  // taking an item in drops the input ready
  a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input ready right after a transfer in");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("stalled result changed");

  // a read hit never reports an accepted insert
  a_read_not_accepted: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[6]) |-> !out_tdata[0])
    else $error("result both read hit and accepted insert");

endmodule

bind top_k_sorted_insert_two_way tksi_chk u_tksi_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ===== tb/sv/top_k_sorted_insert_two_way_tb.sv =====
// Self-checking testbench for the top-K sorted insertion list with stream ports.
module top_k_sorted_insert_two_way_tb;
  import tksi_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int DRAIN_CYCLES = 150;

  typedef struct packed {
    logic              cmd;
    logic [KEY_W-1:0]  key;
    logic [TAG_W-1:0]  tag;
    logic [RIDX_W-1:0] ridx;
  } list_op_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_wr_en;
  logic                  cfg_wr_data;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;   // item_key, item_tag, read_index, zero pad
  logic                  in_tuser;   // command
  logic                  out_tvalid;
  logic                  out_tready;
  // accepted, place, entry_valid, entry_key, entry_tag, fill_count, zero pad
  logic [OUT_DATA_W-1:0] out_tdata;

  // Predicted list contents and order setting.
  logic [KEY_W-1:0] held_keys [LIST_DEPTH];
  logic [TAG_W-1:0] held_tags [LIST_DEPTH];
  int               held_count;
  bit               keep_largest_m;

  list_op_t stim_q [$];
  res_t     result_q [$];
  list_op_t cur_op;
  bit       op_loaded;
  int       burst_left;
  int       gap_left;
  int       err_cnt;
  int       cycle_cnt;
  logic [7:0] stall_pat;
  logic [5:0] stall_step;

  top_k_sorted_insert_two_way u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #1 clk = ~clk;

  // Apply one transfer to the predicted list and return the result it yields.
  function automatic res_t apply_list_op(list_op_t op);
    res_t r;
    int   pos;
    int   last;
    r = '0;
    if (op.cmd == CMD_INSERT) begin
      pos = held_count;
      // scan from the tail so the first winning slot is the one kept
      for (int i = held_count - 1; i >= 0; i--) begin
        if (keep_largest_m ? (op.key >= held_keys[i]) : (op.key <= held_keys[i]))
          pos = i;
      end
      if (pos < LIST_DEPTH) begin
        last = (held_count < LIST_DEPTH) ? held_count : LIST_DEPTH - 1;
        for (int i = last; i > pos; i--) begin
          held_keys[i] = held_keys[i-1];
          held_tags[i] = held_tags[i-1];
        end
        held_keys[pos] = op.key;
        held_tags[pos] = op.tag;
        if (held_count < LIST_DEPTH) held_count++;
        r.accepted = 1'b1;
        r.place    = PLACE_W'(pos);
      end
    end else begin
      r.place = op.ridx;
      if (op.ridx < held_count) begin
        r.entry_valid = 1'b1;
        r.entry_key   = held_keys[op.ridx];
        r.entry_tag   = held_tags[op.ridx];
      end
    end
    r.fill_count = FILL_W'(held_count);
    return r;
  endfunction

  task automatic check_field(input string name, input logic [KEY_W-1:0] want,
                             input logic [KEY_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      err_cnt++;
    end
  endtask

  task automatic push_op(input logic cmd, input logic [KEY_W-1:0] key,
                         input logic [TAG_W-1:0] tag, input logic [RIDX_W-1:0] ridx);
    list_op_t op;
    op.cmd  = cmd;
    op.key  = key;
    op.tag  = tag;
    op.ridx = ridx;
    while (stim_q.size() >= 2) @(posedge clk);
    stim_q.push_back(op);
  endtask

  task automatic wait_drained();
    while (stim_q.size() != 0 || op_loaded || result_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_order(input bit largest);
    wait_drained();
    repeat (4) @(posedge clk);
    cfg_wr_en      <= 1'b1;
    cfg_wr_data    <= largest;
    keep_largest_m = largest;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Half the keys equal or near what the list holds, so ties, shifts and drops all occur.
  task automatic queue_random_ops(input int n);
    logic [KEY_W-1:0] key;
    logic             cmd;
    for (int k = 0; k < n; k++) begin
      cmd = ($urandom_range(0, 2) == 0) ? CMD_READ : CMD_INSERT;
      case ($urandom_range(0, 9))
        0, 1, 2: key = (held_count > 0) ? held_keys[$urandom_range(0, held_count - 1)]
                                        : $urandom;
        3: begin
          case ($urandom_range(0, 3))
            0: key = '0;
            1: key = 32'h0000_0001;
            2: key = 32'hFFFF_FFFE;
            default: key = '1;
          endcase
        end
        4, 5: begin
          key = (held_count > 0) ? held_keys[$urandom_range(0, held_count - 1)] : $urandom;
          key = $urandom_range(0, 1) ? key + 1 : key - 1;
        end
        default: key = $urandom;
      endcase
      push_op(cmd, key, TAG_W'($urandom), RIDX_W'($urandom));
    end
  endtask

  // Sender: bursts of transfers separated by random gaps.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid  <= 1'b0;
      op_loaded  = 1'b0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      if (in_tvalid && in_tready) begin
        result_q.push_back(apply_list_op(cur_op));
        op_loaded = 1'b0;
      end
      if (in_tvalid && !in_tready) begin
        // hold the current transfer
      end else if (gap_left > 0 || stim_q.size() == 0) begin
        if (gap_left > 0) gap_left--;
        in_tvalid <= 1'b0;
      end else begin
        cur_op    = stim_q.pop_front();
        op_loaded = 1'b1;
        in_tvalid <= 1'b1;
        in_tuser  <= cur_op.cmd;
        in_tdata  <= {3'b000, cur_op.ridx, cur_op.tag, cur_op.key};
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 11);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end
      end
    end
  end

  // Receiver: check each result transfer and stall on a rotating pattern.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_pat  <= 8'hFF;
      stall_step <= '0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (result_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %0h", $time, out_tdata);
          err_cnt++;
        end else begin
          res_t want;
          want = result_q.pop_front();
          check_field("accepted", want.accepted, out_tdata[0]);
          check_field("place", want.place, out_tdata[5:1]);
          check_field("entry_valid", want.entry_valid, out_tdata[6]);
          check_field("entry_key", want.entry_key, out_tdata[38:7]);
          check_field("entry_tag", want.entry_tag, out_tdata[54:39]);
          check_field("fill_count", want.fill_count, out_tdata[60:55]);
        end
      end
      stall_step <= stall_step + 1'b1;
      if (stall_step == '1) begin
        case ($urandom_range(0, 3))
          0: stall_pat <= 8'hFF;
          1: stall_pat <= 8'($urandom_range(0, 255)) | 8'h01;
          2: stall_pat <= 8'h11;
          default: stall_pat <= 8'hFE;
        endcase
      end
      out_tready <= stall_pat[stall_step[2:0]];
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    clk            = 1'b0;
    rst_n          = 1'b0;
    cfg_wr_en      = 1'b0;
    cfg_wr_data    = 1'b0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    in_tuser       = CMD_INSERT;
    out_tready     = 1'b0;
    err_cnt        = 0;
    cycle_cnt      = 0;
    held_count     = 0;
    keep_largest_m = 1'b1;
    for (int i = 0; i < LIST_DEPTH; i++) begin
      held_keys[i] = '0;
      held_tags[i] = '0;
    end
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty reads, extremes, ties in the reset order.
    push_op(CMD_READ, '0, '0, 5'd0);
    push_op(CMD_READ, '1, '1, 5'd31);
    push_op(CMD_INSERT, '0, '0, 5'd0);
    push_op(CMD_INSERT, '1, '1, 5'd31);
    push_op(CMD_INSERT, '1, 16'h1234, 5'd0);
    push_op(CMD_INSERT, '0, 16'hAAAA, 5'd0);
    push_op(CMD_INSERT, 32'h8000_0000, 16'h5555, 5'd0);
    push_op(CMD_INSERT, 32'h0000_0001, 16'h8000, 5'd0);
    push_op(CMD_INSERT, 32'h7FFF_FFFF, 16'h7FFF, 5'd0);
    for (int i = 0; i < 8; i++) push_op(CMD_READ, $urandom, TAG_W'($urandom), RIDX_W'(i));
    push_op(CMD_READ, '0, '0, 5'd16);
    push_op(CMD_READ, '0, '0, 5'd31);

    // Flip the order on a partly filled list, then keep flipping once full.
    write_order(1'b0);
    queue_random_ops(260);
    write_order(1'b1);
    queue_random_ops(260);
    write_order(1'b0);
    queue_random_ops(260);
    write_order(1'b1);
    queue_random_ops(250);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
